FILE: rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator: command
// kinds passed from the front end to the back end, result status codes,
// fit policy codes and the fixed field widths.
// ----------------------------------------------------------------------------
package cba_pkg;

    // Default geometry
    localparam int NUM_BLOCKS_DEF      = 16;
    localparam int BYTES_PER_BLOCK_DEF = 10;

    // Widths large enough for the largest supported map (64 blocks)
    localparam int NUM_BLOCKS_MAX = 64;
    localparam int IDX_MAX_W      = $clog2(NUM_BLOCKS_MAX);
    localparam int CNT_MAX_W      = $clog2(NUM_BLOCKS_MAX + 1);

    // Port field widths
    localparam int POLICY_W = 2;
    localparam int BYTES_W  = 8;
    localparam int FSTART_W = 4;
    localparam int FCOUNT_W = 5;
    localparam int STATUS_W = 2;
    localparam int START_W  = 4;

    // Depth of the command queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Fit policy codes; any other code behaves as worst fit
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_NO_ROOM = 2'd1,
        STATUS_BAD     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_BAD     = 2'd2,
        CMD_NO_ROOM = 2'd3
    } t_cmd_kind;

    // Classified request: count is the block count for allocate and free,
    // start is the first block for free
    typedef struct packed {
        t_cmd_kind              kind;
        logic [IDX_MAX_W-1:0]   start;
        logic [CNT_MAX_W-1:0]   count;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } t_back_state;

endpackage

FILE: rtl/cba_front.sv
// ----------------------------------------------------------------------------
// cba_front
// Request front end: rounds the byte count up to whole blocks, checks the
// request against the map size and queues the classified command for the
// back end.
// ----------------------------------------------------------------------------
module cba_front #(
    parameter int NUM_BLOCKS      = cba_pkg::NUM_BLOCKS_DEF,
    parameter int BYTES_PER_BLOCK = cba_pkg::BYTES_PER_BLOCK_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [cba_pkg::BYTES_W-1:0]   i_request_bytes,
    input  logic [cba_pkg::FSTART_W-1:0]  i_free_start,
    input  logic [cba_pkg::FCOUNT_W-1:0]  i_free_count,
    output logic                          o_cmd_valid,
    output cba_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);
    import cba_pkg::*;

    // Ceiling division by a constant: multiply by a rounded-up reciprocal.
    // Exact for sums below 2^16 / BYTES_PER_BLOCK.
    localparam int SUM_W       = BYTES_W + 1;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP       = (2 ** RECIP_SHIFT + BYTES_PER_BLOCK - 1) / BYTES_PER_BLOCK;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int FSUM_W      = FCOUNT_W + 2;
    localparam int QD          = QUEUE_DEPTH;
    localparam int PTR_W       = $clog2(QD);
    localparam int QCNT_W      = $clog2(QD + 1);

    logic [SUM_W-1:0]  bytes_sum;
    logic [PROD_W-1:0] product;
    logic [SUM_W-1:0]  need;
    logic [FSUM_W-1:0] free_end;
    t_cmd              cmd;
    logic              push;

    t_cmd              r_q [QD];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    // Round the byte count up to blocks
    assign bytes_sum = {1'b0, i_request_bytes} + SUM_W'(BYTES_PER_BLOCK - 1);
    assign product   = PROD_W'(bytes_sum) * PROD_W'(RECIP);
    assign need      = product[RECIP_SHIFT +: SUM_W];
    assign free_end  = FSUM_W'(i_free_start) + FSUM_W'(i_free_count);

    // Classify the request
    always_comb begin
        cmd.start = IDX_MAX_W'(i_free_start);
        cmd.count = CNT_MAX_W'(i_free_count);
        cmd.kind  = CMD_FREE;
        if (!i_mode) begin
            cmd.count = CNT_MAX_W'(need);
            if (i_request_bytes == '0) begin
                cmd.kind = CMD_BAD;
            end else if (int'(need) > NUM_BLOCKS) begin
                cmd.kind = CMD_NO_ROOM;
            end else begin
                cmd.kind = CMD_ALLOC;
            end
        end else if (i_free_count == '0 || int'(free_end) > NUM_BLOCKS) begin
            cmd.kind = CMD_BAD;
        end
    end

    // Queue control
    assign o_stall     = (r_count == QCNT_W'(QD));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push      ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(push) - QCNT_W'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the request entry
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= QD)
        else $error("command queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_count != '0)
        else $error("pop from empty command queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_cmd_pop) |=> r_count == $past(r_count) + QCNT_W'(1))
        else $error("command queue count lost a request");
`endif

endmodule

FILE: rtl/cba_back.sv
// ----------------------------------------------------------------------------
// cba_back
// Allocator back end: holds the occupancy map and the fit policy, scans the
// map one block per cycle for an allocate, marks or clears runs and keeps
// the result in an output register.
// ----------------------------------------------------------------------------
module cba_back #(
    parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cba_pkg::POLICY_W-1:0]  i_cfg_wr_data,
    input  logic                          i_cmd_valid,
    input  cba_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cba_pkg::STATUS_W-1:0]  o_status,
    output logic [cba_pkg::START_W-1:0]   o_start_index
);
    import cba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [NUM_BLOCKS-1:0] r_map;
    logic [NUM_BLOCKS-1:0] n_map;
    logic [POLICY_W-1:0]   r_fit_policy;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      n_idx;
    logic [CNT_W-1:0]      r_need;
    logic [CNT_W-1:0]      n_need;
    logic [CNT_W-1:0]      r_run_len;
    logic [CNT_W-1:0]      n_run_len;
    logic [IDX_W-1:0]      r_run_start;
    logic [IDX_W-1:0]      n_run_start;
    logic [CNT_W-1:0]      r_best_len;
    logic [CNT_W-1:0]      n_best_len;
    logic [IDX_W-1:0]      r_best_start;
    logic [IDX_W-1:0]      n_best_start;
    logic                  r_found;
    logic                  n_found;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [IDX_W-1:0]      r_start;
    logic [IDX_W-1:0]      n_start;

    logic                  out_free;
    logic                  free_here;
    logic                  run_fits;
    logic                  take_run;
    logic                  scan_stop;
    logic                  load;
    logic [NUM_BLOCKS-1:0] free_mask;
    logic [NUM_BLOCKS-1:0] alloc_mask;
    logic [IDX_MAX_W-1:0]  start_ext;

    // Output register frees up when empty or being taken
    assign out_free  = !r_out_valid || !i_stall;
    assign o_cmd_pop = (r_state == BK_IDLE) && i_cmd_valid && out_free;

    // One step of the run scan
    always_comb begin
        free_here = (int'(r_idx) < NUM_BLOCKS) && !r_map[r_idx[IDX_W-1:0]];
        run_fits  = !free_here && (r_run_len >= r_need) && (r_run_len != '0);
        take_run  = 1'b0;
        if (run_fits) begin
            if (!r_found) begin
                take_run = 1'b1;
            end else if (r_fit_policy == POLICY_BEST) begin
                take_run = (r_run_len < r_best_len);
            end else if (r_fit_policy != POLICY_FIRST) begin
                take_run = (r_run_len > r_best_len);
            end
        end
        scan_stop = (int'(r_idx) == NUM_BLOCKS) ||
                    (run_fits && r_fit_policy == POLICY_FIRST);
    end

    // Run masks for free and allocate
    always_comb begin
        for (int j = 0; j < NUM_BLOCKS; j++) begin
            free_mask[j]  = (j >= int'(i_cmd.start)) &&
                            (j < int'(i_cmd.start) + int'(i_cmd.count));
            alloc_mask[j] = (j >= int'(r_best_start)) &&
                            (j < int'(r_best_start) + int'(r_need));
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (o_cmd_pop && i_cmd.kind == CMD_ALLOC) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (scan_stop) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb begin
        n_map        = r_map;
        n_idx        = r_idx;
        n_need       = r_need;
        n_run_len    = r_run_len;
        n_run_start  = r_run_start;
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_found      = r_found;
        n_status     = r_status;
        n_start      = r_start;
        load         = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (o_cmd_pop) begin
                    n_start = '0;
                    case (i_cmd.kind)
                        CMD_ALLOC: begin
                            n_need    = CNT_W'(i_cmd.count);
                            n_idx     = '0;
                            n_run_len = '0;
                            n_found   = 1'b0;
                        end
                        CMD_FREE: begin
                            n_map    = r_map & ~free_mask;
                            n_status = STATUS_DONE;
                            load     = 1'b1;
                        end
                        CMD_NO_ROOM: begin
                            n_status = STATUS_NO_ROOM;
                            load     = 1'b1;
                        end
                        default: begin
                            n_status = STATUS_BAD;
                            load     = 1'b1;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                n_idx = r_idx + CNT_W'(1);
                if (free_here) begin
                    n_run_len = r_run_len + CNT_W'(1);
                    if (r_run_len == '0) begin
                        n_run_start = r_idx[IDX_W-1:0];
                    end
                end else begin
                    n_run_len = '0;
                    if (take_run) begin
                        n_found      = 1'b1;
                        n_best_len   = r_run_len;
                        n_best_start = r_run_start;
                    end
                end
            end
            BK_FINISH: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_found) begin
                        n_map    = r_map | alloc_mask;
                        n_status = STATUS_DONE;
                        n_start  = r_best_start;
                    end else begin
                        n_status = STATUS_NO_ROOM;
                        n_start  = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out_valid = (r_out_valid && i_stall) || load;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_map        <= '0;
            r_fit_policy <= POLICY_WORST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_fit_policy <= i_cfg_wr_data;
            end
        end
    end

    // Scan and result payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_need       <= n_need;
        r_run_len    <= n_run_len;
        r_run_start  <= n_run_start;
        r_best_len   <= n_best_len;
        r_best_start <= n_best_start;
        r_found      <= n_found;
        r_status     <= n_status;
        r_start      <= n_start;
    end

    assign start_ext     = IDX_MAX_W'(r_start);
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_start_index = start_ext[START_W-1:0];

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_SCAN |-> int'(r_idx) <= NUM_BLOCKS)
        else $error("scan index ran past the map");
    a_map_held_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_SCAN |=> $stable(r_map))
        else $error("map changed during a scan");
    a_run_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FINISH && r_found) |->
            int'(r_best_start) + int'(r_need) <= NUM_BLOCKS)
        else $error("chosen run extends beyond the map");
    a_run_was_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FINISH && r_found) |-> (r_map & alloc_mask) == '0)
        else $error("chosen run overlaps occupied blocks");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid && $stable(r_status))
        else $error("waiting result overwritten");
`endif

endmodule

FILE: rtl/contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// Bitmap allocator of equal-size blocks with first, best or worst fit.
//
//   channel  direction  handshake             payload
//   request  in         i_valid / o_stall     i_mode, i_request_bytes,
//                                             i_free_start, i_free_count
//   result   out        o_valid / i_stall     o_status, o_start_index
//   config   in         i_cfg_wr_en           i_cfg_wr_data (fit policy)
//
// In the back end an allocate pops the command, scans the map at one block per
// cycle (first fit stops at the first run that fits) and then marks the run
// once the output register is free. Free and rejected requests are answered
// when they are popped, with no scan.
// Reset is synchronous; it empties the map, sets worst fit and drops any
// queued request. A two-entry queue lets requests arrive while a result is
// stalled at the output register.
// ----------------------------------------------------------------------------
module contiguous_block_allocator #(
    parameter int NUM_BLOCKS      = cba_pkg::NUM_BLOCKS_DEF,
    parameter int BYTES_PER_BLOCK = cba_pkg::BYTES_PER_BLOCK_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cba_pkg::POLICY_W-1:0]  i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [cba_pkg::BYTES_W-1:0]   i_request_bytes,
    input  logic [cba_pkg::FSTART_W-1:0]  i_free_start,
    input  logic [cba_pkg::FCOUNT_W-1:0]  i_free_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cba_pkg::STATUS_W-1:0]  o_status,
    output logic [cba_pkg::START_W-1:0]   o_start_index
);
    import cba_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Classify and queue requests
    cba_front #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_free_start    (i_free_start),
        .i_free_count    (i_free_count),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    // Scan, mark and report
    cba_back #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_start_index (o_start_index)
    );

endmodule
